/* hdl/ktidf_pkg.sv */
// Shared types and constants for the keyed record table.
package ktidf_pkg;

    localparam int TABLE_DEPTH_DEF = 128;

    localparam int KEY_W   = 31;
    localparam int PRICE_W = 24;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int REC_W   = KEY_W + PRICE_W + DAY_W + MONTH_W + YEAR_W;
    localparam int COUNT_W = 8;

    localparam int IN_TDATA_W  = ((REC_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((REC_W + COUNT_W + 7) / 8) * 8;

    // The key is the last member so that it lands in the lowest bits.
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [PRICE_W-1:0] price;
        logic [KEY_W-1:0]   key;
    } t_rec;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_FIND   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_NOTFOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } t_state;

endpackage

/* hdl/ktidf_ram.sv */
// Record memory with one write port and one registered read port.
module ktidf_ram #(
    parameter int DEPTH = ktidf_pkg::TABLE_DEPTH_DEF,
    parameter int AW    = 7
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  ktidf_pkg::t_rec     i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output ktidf_pkg::t_rec     o_rdata
);

    ktidf_pkg::t_rec r_mem [DEPTH];
    ktidf_pkg::t_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/keyed_table_insert_delete_find.sv */
// Keyed record table: records are kept in insertion order in one memory with a registered
// read, and the block handles one command at a time. An insert or the unused command goes
// straight from idle to the finish state. A find reads one entry a cycle from the start of
// the table until the first key match; when the key is absent it reads every entry and
// reports not found. A delete scans the same way and then moves every later record down one
// place, one per cycle, overlapping the read of one entry with the write of the one below;
// the single read port of the memory sets the pace of both passes. A new beat is taken
// while the previous result still waits at the output.
module keyed_table_insert_delete_find #(
    parameter int TABLE_DEPTH = ktidf_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // key, price_cents, expiry_day, expiry_month, expiry_year, zero pad
    input  logic [ktidf_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // cmd
    input  logic [1:0]                          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // found_key, found_price_cents, found_day, found_month, found_year, entry_count, zero pad
    output logic [ktidf_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // status
    output logic [1:0]                          o_m_axis_tuser
);

    localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int PAD = ktidf_pkg::OUT_TDATA_W - ktidf_pkg::REC_W - ktidf_pkg::COUNT_W;

    ktidf_pkg::t_state  r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_rd_idx, n_rd_idx;
    logic               r_rd_vld, n_rd_vld;
    ktidf_pkg::t_cmd    r_cmd, n_cmd;
    logic [ktidf_pkg::KEY_W-1:0] r_key, n_key;
    ktidf_pkg::t_status r_res_status, n_res_status;
    ktidf_pkg::t_rec    r_res_rec, n_res_rec;
    logic               r_out_vld, n_out_vld;
    ktidf_pkg::t_status r_out_status, n_out_status;
    ktidf_pkg::t_rec    r_out_rec, n_out_rec;
    logic [ktidf_pkg::COUNT_W-1:0] r_out_count, n_out_count;

    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    ktidf_pkg::t_rec    ram_wdata;
    logic [IW-1:0]      ram_raddr;
    ktidf_pkg::t_rec    ram_rdata;

    logic               in_beat;
    logic               out_free;
    logic               hit;
    logic               scan_more;
    logic               shift_more;
    logic [CW:0]        idx_inc;

    ktidf_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_axis_tready = (r_state == ktidf_pkg::ST_IDLE);
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_vld || i_m_axis_tready;
    assign idx_inc         = {1'b0, r_idx} + (CW+1)'(1);
    assign scan_more       = (r_idx < r_count);
    assign shift_more      = (idx_inc < {1'b0, r_count});
    assign hit             = r_rd_vld && (ram_rdata.key == r_key);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ktidf_pkg::ST_IDLE: begin
                if (in_beat) begin
                    case (ktidf_pkg::t_cmd'(i_s_axis_tuser))
                        ktidf_pkg::CMD_DELETE, ktidf_pkg::CMD_FIND: n_state = ktidf_pkg::ST_SCAN;
                        default: n_state = ktidf_pkg::ST_FINISH;
                    endcase
                end
            end
            ktidf_pkg::ST_SCAN: begin
                if (hit) begin
                    n_state = (r_cmd == ktidf_pkg::CMD_DELETE) ? ktidf_pkg::ST_SHIFT
                                                               : ktidf_pkg::ST_FINISH;
                end else if (!scan_more && !r_rd_vld) begin
                    n_state = ktidf_pkg::ST_FINISH;
                end
            end
            ktidf_pkg::ST_SHIFT: begin
                if (!shift_more && !r_rd_vld) begin
                    n_state = ktidf_pkg::ST_FINISH;
                end
            end
            ktidf_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = ktidf_pkg::ST_IDLE;
                end
            end
            default: n_state = ktidf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_idx        = r_idx;
        n_rd_idx     = r_rd_idx;
        n_rd_vld     = r_rd_vld;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_res_status = r_res_status;
        n_res_rec    = r_res_rec;
        n_out_vld    = r_out_vld && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_rec    = r_out_rec;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_waddr    = r_rd_idx[IW-1:0];
        ram_wdata    = ram_rdata;
        ram_raddr    = r_idx[IW-1:0];
        case (r_state)
            ktidf_pkg::ST_IDLE: begin
                if (in_beat) begin
                    n_cmd        = ktidf_pkg::t_cmd'(i_s_axis_tuser);
                    n_key        = i_s_axis_tdata[ktidf_pkg::KEY_W-1:0];
                    n_idx        = '0;
                    n_rd_vld     = 1'b0;
                    n_res_status = ktidf_pkg::STAT_OK;
                    n_res_rec    = '0;
                    if (ktidf_pkg::t_cmd'(i_s_axis_tuser) == ktidf_pkg::CMD_INSERT) begin
                        if (r_count < CW'(TABLE_DEPTH)) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_count[IW-1:0];
                            ram_wdata = ktidf_pkg::t_rec'(i_s_axis_tdata[ktidf_pkg::REC_W-1:0]);
                            n_count   = r_count + CW'(1);
                        end else begin
                            n_res_status = ktidf_pkg::STAT_FULL;
                        end
                    end
                end
            end
            ktidf_pkg::ST_SCAN: begin
                // Reads are issued back to back; each compare sees the entry read a cycle ago.
                if (hit) begin
                    n_rd_vld = 1'b0;
                    if (r_cmd == ktidf_pkg::CMD_DELETE) begin
                        n_idx = r_rd_idx;
                    end else begin
                        n_res_rec = ram_rdata;
                    end
                end else begin
                    n_rd_vld = scan_more;
                    n_rd_idx = r_idx;
                    if (scan_more) begin
                        n_idx = idx_inc[CW-1:0];
                    end else if (!r_rd_vld) begin
                        n_res_status = ktidf_pkg::STAT_NOTFOUND;
                    end
                end
            end
            ktidf_pkg::ST_SHIFT: begin
                // Read the entry above while the one read last cycle is written one place down.
                ram_raddr = idx_inc[IW-1:0];
                ram_we    = r_rd_vld;
                n_rd_vld  = shift_more;
                n_rd_idx  = r_idx;
                if (shift_more) begin
                    n_idx = idx_inc[CW-1:0];
                end else if (!r_rd_vld) begin
                    n_count = r_count - CW'(1);
                end
            end
            ktidf_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_status = r_res_status;
                    n_out_rec    = r_res_rec;
                    n_out_count  = ktidf_pkg::COUNT_W'(r_count);
                end
            end
            default: begin
                n_rd_vld = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ktidf_pkg::ST_IDLE;
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_rd_idx     <= n_rd_idx;
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_res_status <= n_res_status;
        r_res_rec    <= n_res_rec;
        r_out_status <= n_out_status;
        r_out_rec    <= n_out_rec;
        r_out_count  <= n_out_count;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {{PAD{1'b0}}, r_out_count, r_out_rec};

endmodule
